// ----- sv/assert_macros.svh -----
// Assertion macros shared by the vertex transform RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define VTP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define VTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/vtp_pkg.sv -----
// Package for the vertex transform: shared types and constants.
// No dependencies.
package vtp_pkg;
    localparam int PROJ_SHIFT = 8;
    localparam int NUM_W = 16 + PROJ_SHIFT;   // numerator width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic signed [15:0] CENTER_RESET = 16'sd88;
    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN = -16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X    = 3'd0,
        REG_ROW_Y    = 3'd1,
        REG_ROW_Z    = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4
    } cfg_idx_t;

    // One division lane as it moves down the chain of cells.
    typedef struct packed {
        logic                    neg;    // quotient sign
        logic [NUM_W-1:0]        rem;    // partial remainder (magnitude)
        logic [NUM_W-1:0]        quo;    // numerator bits shifted out / quotient bits
    } div_lane_t;

    // Side data carried alongside the divider.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               zero;        // depth was zero
        logic               neg_x;       // numerator signs for zero depth
        logic               neg_y;
        logic signed [15:0] depth;
        logic [15:0]        dmag;        // |depth|
    } div_ctl_t;
endpackage

// ----- sv/vertex_transform_project.sv -----
// Vertex transform with perspective divide: one vertex accepted every cycle, busy
// is held low throughout. The divider is a chain of 24 division cells, one quotient
// bit each. Reset (rst_n, asynchronous) clears the valid pipeline and the registers
// to zero rows and centre 88. The receiver cannot stall; results are strobed.
module vertex_transform_project #(
    parameter int FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] model_x,
    input  logic signed [15:0] model_y,
    input  logic signed [15:0] model_z,
    input  logic               last_vertex,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic signed [15:0] view_depth,
    output logic               divide_error,
    output logic               last_out
);
    localparam int NW = vtp_pkg::NUM_W;

    // Configuration registers: user writes only while pipeline empty; unenforced.
    logic [63:0]        row_x_reg, row_y_reg, row_z_reg;
    logic signed [15:0] center_x_reg, center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg    <= '0;
            row_y_reg    <= '0;
            row_z_reg    <= '0;
            center_x_reg <= vtp_pkg::CENTER_RESET;
            center_y_reg <= vtp_pkg::CENTER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vtp_pkg::REG_ROW_X:    row_x_reg    <= cfg_data;
                vtp_pkg::REG_ROW_Y:    row_y_reg    <= cfg_data;
                vtp_pkg::REG_ROW_Z:    row_z_reg    <= cfg_data;
                vtp_pkg::REG_CENTER_X: center_x_reg <= cfg_data[15:0];
                vtp_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The block never refuses a beat.
    assign busy = 1'b0;

    // Transform stage: two register levels inside each row unit.
    logic signed [15:0] xp, yp, zp;
    vtp_row #(.FRAC_BITS(FRAC_BITS)) u_row_x (.clk(clk), .row(row_x_reg),
        .x(model_x), .y(model_y), .z(model_z), .d(xp));
    vtp_row #(.FRAC_BITS(FRAC_BITS)) u_row_y (.clk(clk), .row(row_y_reg),
        .x(model_x), .y(model_y), .z(model_z), .d(yp));
    vtp_row #(.FRAC_BITS(FRAC_BITS)) u_row_z (.clk(clk), .row(row_z_reg),
        .x(model_x), .y(model_y), .z(model_z), .d(zp));

    logic [1:0] v_pipe_reg;
    logic [1:0] l_pipe_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_pipe_reg <= '0;
        else
            v_pipe_reg <= {v_pipe_reg[0], start};
    end
    always_ff @(posedge clk)
    begin
        l_pipe_reg <= {l_pipe_reg[0], last_vertex};
    end

    // Set-up stage: magnitudes and signs for the divider chain.
    vtp_pkg::div_ctl_t  ctl_reg;
    vtp_pkg::div_lane_t lx_reg, ly_reg;
    logic [NW-1:0]      nx_mag, ny_mag;
    logic [15:0]        z_mag;

    always_comb
    begin
        nx_mag = xp[15] ? NW'(-{xp, 8'b0}) : NW'({xp, 8'b0});
        ny_mag = yp[15] ? NW'(-{yp, 8'b0}) : NW'({yp, 8'b0});
        z_mag  = zp[15] ? 16'(-zp) : 16'(zp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
        begin
            ctl_reg.valid <= v_pipe_reg[1];
            ctl_reg.last  <= l_pipe_reg[1];
            ctl_reg.zero  <= (zp == 16'sd0);
            ctl_reg.neg_x <= xp[15];
            ctl_reg.neg_y <= yp[15];
            ctl_reg.depth <= zp;
            ctl_reg.dmag  <= z_mag;
        end
    end
    always_ff @(posedge clk)
    begin
        lx_reg        <= '{neg: xp[15] ^ zp[15], rem: '0, quo: nx_mag};
        ly_reg        <= '{neg: yp[15] ^ zp[15], rem: '0, quo: ny_mag};
    end

    // Chain of division cells, one quotient bit each.
    vtp_pkg::div_ctl_t  ctl_c [NW+1];
    vtp_pkg::div_lane_t lx_c  [NW+1];
    vtp_pkg::div_lane_t ly_c  [NW+1];
    logic signed [15:0] cx_c  [NW+1];
    logic signed [15:0] cy_c  [NW+1];

    assign ctl_c[0] = ctl_reg;
    assign lx_c[0]  = lx_reg;
    assign ly_c[0]  = ly_reg;
    assign cx_c[0]  = center_x_reg;
    assign cy_c[0]  = center_y_reg;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        vtp_div_cell u_cell (
            .clk(clk), .rst_n(rst_n),
            .ctl_in(ctl_c[i]), .lx_in(lx_c[i]), .ly_in(ly_c[i]),
            .cx_in(cx_c[i]), .cy_in(cy_c[i]),
            .ctl_out(ctl_c[i+1]), .lx_out(lx_c[i+1]), .ly_out(ly_c[i+1]),
            .cx_out(cx_c[i+1]), .cy_out(cy_c[i+1])
        );
    end

    // Saturation, sign and centre addition, then the result register.
    vtp_pkg::div_ctl_t  ctl_e;
    logic signed [15:0] qx, qy;
    logic               ex, ey;

    function automatic logic [16:0] finish(vtp_pkg::div_lane_t l, logic zero, logic nneg);
        logic [15:0] q;
        logic        ov;
        if (zero)
        begin
            q  = nneg ? vtp_pkg::Q_MIN : vtp_pkg::Q_MAX;
            ov = 1'b1;
        end
        else if (!l.neg)
        begin
            ov = (l.quo > NW'(32767));
            q  = ov ? vtp_pkg::Q_MAX : l.quo[15:0];
        end
        else
        begin
            ov = (l.quo > NW'(32768));
            q  = ov ? vtp_pkg::Q_MIN : 16'(-l.quo[15:0]);
        end
        return {ov, q};
    endfunction

    always_comb
    begin
        ctl_e    = ctl_c[NW];
        {ex, qx} = finish(lx_c[NW], ctl_e.zero, ctl_e.neg_x);
        {ey, qy} = finish(ly_c[NW], ctl_e.zero, ctl_e.neg_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= ctl_e.valid;
    end
    always_ff @(posedge clk)
    begin
        screen_x     <= qx + cx_c[NW];
        screen_y     <= qy + cy_c[NW];
        view_depth   <= ctl_e.depth;
        divide_error <= ex | ey;
        last_out     <= ctl_e.last;
    end

    `include "assert_macros.svh"
    `VTP_ASSERT_NEXT(a_zero_err, clk, rst_n, ctl_e.valid && ctl_e.zero, divide_error && done, "zero depth without error")
    `VTP_ASSERT_NEXT(a_done_follows, clk, rst_n, ctl_e.valid, done, "result strobe lost")
    `VTP_ASSERT_IMP(a_not_busy, clk, rst_n, 1'b1, !busy, "busy raised")
endmodule

// ----- sv/vtp_row.sv -----
// One matrix row applied with the pairwise-product trick, two register stages.
// No dependencies; nothing from vtp_pkg is used.
module vtp_row #(
    parameter int FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic [63:0]        row,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic signed [15:0] z,
    output logic signed [15:0] d
);
    logic signed [15:0] a, b, c, t;
    logic signed [34:0] p1_reg, p1_next;
    logic signed [31:0] p2_reg, p3_reg, ab_reg;
    logic signed [15:0] t_reg;
    logic signed [35:0] psum;
    logic signed [35:0] dsum;

    assign a = row[15:0];
    assign b = row[31:16];
    assign c = row[47:32];
    assign t = row[63:48];

    always_comb
    begin
        p1_next = 35'(($signed({a[15], a}) + $signed({y[15], y}))
                    * ($signed({b[15], b}) + $signed({x[15], x})));
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        p2_reg <= c * z;
        p3_reg <= x * y;
        ab_reg <= a * b;
        t_reg  <= t;
    end

    always_comb
    begin
        psum = 36'(p1_reg) + 36'(p2_reg) - 36'(p3_reg);
        dsum = (psum >>> FRAC_BITS) + 36'(t_reg) - (36'(ab_reg) >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        d <= dsum[15:0];
    end
endmodule

// ----- sv/vtp_div_cell.sv -----
// One restoring-division cell: retires one quotient bit per lane per cycle.
// Depends on vtp_pkg.
module vtp_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vtp_pkg::div_ctl_t     ctl_in,
    input  vtp_pkg::div_lane_t    lx_in,
    input  vtp_pkg::div_lane_t    ly_in,
    input  logic signed [15:0]    cx_in,
    input  logic signed [15:0]    cy_in,
    output vtp_pkg::div_ctl_t     ctl_out,
    output vtp_pkg::div_lane_t    lx_out,
    output vtp_pkg::div_lane_t    ly_out,
    output logic signed [15:0]    cx_out,
    output logic signed [15:0]    cy_out
);
    function automatic vtp_pkg::div_lane_t step(vtp_pkg::div_lane_t l, logic [15:0] dm);
        logic [vtp_pkg::NUM_W:0] trial;
        vtp_pkg::div_lane_t      r;
        trial = {l.rem, l.quo[vtp_pkg::NUM_W-1]} - {{(vtp_pkg::NUM_W-15){1'b0}}, dm};
        r.neg = l.neg;
        if (!trial[vtp_pkg::NUM_W])
        begin
            r.rem = trial[vtp_pkg::NUM_W-1:0];
            r.quo = {l.quo[vtp_pkg::NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = {l.rem[vtp_pkg::NUM_W-2:0], l.quo[vtp_pkg::NUM_W-1]};
            r.quo = {l.quo[vtp_pkg::NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_out <= '0;
        else
            ctl_out <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        lx_out        <= step(lx_in, ctl_in.dmag);
        ly_out        <= step(ly_in, ctl_in.dmag);
        cx_out        <= cx_in;
        cy_out        <= cy_in;
    end
endmodule
